// ===== sv/smac_pkg.sv =====
package smac_pkg;

	localparam int AXIS_W     = 16;
	localparam int NUM_AXES   = 6;
	localparam int TICK_W     = 16;
	localparam int GRAV_W     = 15;
	localparam int CFG_DATA_W = 16;

	// axis order inside the per-axis arrays
	localparam int AX_ACCEL_X = 0;
	localparam int AX_ACCEL_Y = 1;
	localparam int AX_ACCEL_Z = 2;
	localparam int AX_RATE_X  = 3;
	localparam int AX_RATE_Y  = 4;
	localparam int AX_RATE_Z  = 5;

	localparam logic [TICK_W-1:0] WIN_START_RST = 16'd4000;
	localparam logic [TICK_W-1:0] WIN_END_RST   = 16'd4400;
	localparam logic [GRAV_W-1:0] GRAVITY_RST   = 15'd4096;

	typedef enum logic [1:0] {
		CFG_WIN_START   = 2'd0,
		CFG_WIN_END     = 2'd1,
		CFG_UPSIDE_DOWN = 2'd2,
		CFG_GRAVITY     = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic                     operation;
		logic signed [AXIS_W-1:0] raw_accel_x;
		logic signed [AXIS_W-1:0] raw_accel_y;
		logic signed [AXIS_W-1:0] raw_accel_z;
		logic signed [AXIS_W-1:0] raw_rate_x;
		logic signed [AXIS_W-1:0] raw_rate_y;
		logic signed [AXIS_W-1:0] raw_rate_z;
		logic        [TICK_W-1:0] tick_ms;
	} in_word_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] accel_x;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] accel_z;
		logic signed [AXIS_W-1:0] rate_x;
		logic signed [AXIS_W-1:0] rate_y;
		logic signed [AXIS_W-1:0] rate_z;
	} out_word_t;

endpackage

// ===== sv/six_axis_moving_average_calibrate.sv =====
// throughput: one word per cycle while result_ready is high; five register stages
// (input, sum, reciprocal multiply, sign restore, output with offset update) each take a
// new word when the next one frees
// reset: arst_n clears sample histories, running sums, averages and offsets to zero and
// loads the window 4000..4400, upright mount and 4096 counts per g
module six_axis_moving_average_calibrate #(
	parameter int WINDOW_LEN = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  smac_pkg::in_word_t                   sample,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output smac_pkg::out_word_t                  result,
	input  logic                                 wr_en,
	input  smac_pkg::cfg_index_t                 wr_index,
	input  logic [smac_pkg::CFG_DATA_W-1:0]      wr_data
);
	import smac_pkg::*;

	localparam int LOG_W  = $clog2(WINDOW_LEN);
	localparam int SUM_W  = AXIS_W + LOG_W;
	localparam int SHIFT  = SUM_W + LOG_W;
	localparam int RCP_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam int QUO_W  = AXIS_W + 1;
	localparam longint unsigned RCP_L =
		((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_L);

	// configuration
	logic [TICK_W-1:0] win_start_q;
	logic [TICK_W-1:0] win_end_q;
	logic              upside_q;
	logic [GRAV_W-1:0] grav_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= WIN_START_RST;
			win_end_q   <= WIN_END_RST;
			upside_q    <= 1'b0;
			grav_q      <= GRAVITY_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_WIN_START:   win_start_q <= wr_data[TICK_W-1:0];
				CFG_WIN_END:     win_end_q   <= wr_data[TICK_W-1:0];
				CFG_UPSIDE_DOWN: upside_q    <= wr_data[0];
				CFG_GRAVITY:     grav_q      <= wr_data[GRAV_W-1:0];
				default:         win_start_q <= win_start_q;
			endcase
		end
	end

	// handshake chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_o;
	logic mv_s1, mv_s4;

	assign rdy_o  = !vld_q || result_ready;
	assign rdy_s4 = !vld_s4 || rdy_o;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign mv_s1  = vld_s1 && rdy_s2;
	assign mv_s4  = vld_s4 && rdy_o;

	assign sample_ready = rdy_s1;
	assign result_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= sample_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_o)  vld_q  <= vld_s4;
		end
	end

	// stage 1: input word, running sums and sample histories
	in_word_t                  sample_s1;
	logic signed [AXIS_W-1:0]  raw_s1   [NUM_AXES];
	logic signed [AXIS_W-1:0]  hist_q   [NUM_AXES][WINDOW_LEN];
	logic signed [SUM_W-1:0]   sum_q    [NUM_AXES];
	logic signed [SUM_W-1:0]   sum_nxt  [NUM_AXES];
	logic        [SUM_W-1:0]   mag_nxt  [NUM_AXES];
	logic                      win_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) sample_s1 <= sample;
	end

	assign raw_s1[AX_ACCEL_X] = sample_s1.raw_accel_x;
	assign raw_s1[AX_ACCEL_Y] = sample_s1.raw_accel_y;
	assign raw_s1[AX_ACCEL_Z] = sample_s1.raw_accel_z;
	assign raw_s1[AX_RATE_X]  = sample_s1.raw_rate_x;
	assign raw_s1[AX_RATE_Y]  = sample_s1.raw_rate_y;
	assign raw_s1[AX_RATE_Z]  = sample_s1.raw_rate_z;

	assign win_s1 = (sample_s1.tick_ms >= win_start_q) && (sample_s1.tick_ms <= win_end_q);

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			sum_nxt[a] = sum_q[a]
				- {{(SUM_W-AXIS_W){hist_q[a][0][AXIS_W-1]}}, hist_q[a][0]}
				+ {{(SUM_W-AXIS_W){raw_s1[a][AXIS_W-1]}}, raw_s1[a]};
			mag_nxt[a] = sum_nxt[a][SUM_W-1] ? (SUM_W'(0) - sum_nxt[a]) : sum_nxt[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				sum_q[a] <= '0;
				for (int i = 0; i < WINDOW_LEN; i++) begin
					hist_q[a][i] <= '0;
				end
			end
		end else if (mv_s1 && sample_s1.operation) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				sum_q[a] <= sum_nxt[a];
				for (int i = 0; i < WINDOW_LEN - 1; i++) begin
					hist_q[a][i] <= hist_q[a][i+1];
				end
				hist_q[a][WINDOW_LEN-1] <= raw_s1[a];
			end
		end
	end

	// stage 2: magnitude of the new sums
	logic               push_s2, win_s2;
	logic               neg_s2  [NUM_AXES];
	logic [SUM_W-1:0]   mag_s2  [NUM_AXES];
	logic [PROD_W-1:0]  prod    [NUM_AXES];

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			push_s2 <= sample_s1.operation;
			win_s2  <= win_s1;
			for (int a = 0; a < NUM_AXES; a++) begin
				neg_s2[a] <= sum_nxt[a][SUM_W-1];
				mag_s2[a] <= mag_nxt[a];
			end
		end
	end

	// divide by the window length as a multiply by its scaled reciprocal
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			prod[a] = PROD_W'(mag_s2[a]) * PROD_W'(RECIP);
		end
	end

	// stage 3: quotient magnitudes
	logic               push_s3, win_s3;
	logic               neg_s3  [NUM_AXES];
	logic [QUO_W-1:0]   quo_s3  [NUM_AXES];
	logic [QUO_W-1:0]   sgn_quo [NUM_AXES];

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			push_s3 <= push_s2;
			win_s3  <= win_s2;
			for (int a = 0; a < NUM_AXES; a++) begin
				neg_s3[a] <= neg_s2[a];
				quo_s3[a] <= prod[a][SHIFT +: QUO_W];
			end
		end
	end

	// truncation toward zero: restore the sign after the unsigned divide
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			sgn_quo[a] = neg_s3[a] ? (QUO_W'(0) - quo_s3[a]) : quo_s3[a];
		end
	end

	// stage 4: new averages
	logic                      push_s4, win_s4;
	logic signed [AXIS_W-1:0]  avg_s4 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			push_s4 <= push_s3;
			win_s4  <= win_s3;
			for (int a = 0; a < NUM_AXES; a++) begin
				avg_s4[a] <= sgn_quo[a][AXIS_W-1:0];
			end
		end
	end

	// output stage: averages, offsets and the result word
	logic signed [AXIS_W-1:0]  avg_q   [NUM_AXES];
	logic signed [AXIS_W-1:0]  off_q   [NUM_AXES];
	logic signed [AXIS_W-1:0]  cur     [NUM_AXES];
	logic signed [AXIS_W-1:0]  off_nxt [NUM_AXES];
	logic signed [AXIS_W-1:0]  res     [NUM_AXES];
	logic signed [AXIS_W-1:0]  cur_z;
	logic                      capture;
	out_word_t                 result_q;
	out_word_t                 result_nxt;

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			cur[a]     = push_s4 ? avg_s4[a] : avg_q[a];
			off_nxt[a] = off_q[a];
			res[a]     = cur[a] - off_q[a];
		end
		capture = push_s4 && win_s4;
		cur_z   = upside_q ? (AXIS_W'(0) - cur[AX_ACCEL_Z]) : cur[AX_ACCEL_Z];
		res[AX_ACCEL_Z] = cur_z - off_q[AX_ACCEL_Z];
		if (capture) begin
			off_nxt[AX_ACCEL_X] = AXIS_W'(0) - cur[AX_ACCEL_X];
			off_nxt[AX_ACCEL_Y] = cur[AX_ACCEL_Y];
			off_nxt[AX_ACCEL_Z] = cur_z - {1'b0, grav_q};
			off_nxt[AX_RATE_X]  = cur[AX_RATE_X];
			off_nxt[AX_RATE_Y]  = cur[AX_RATE_Y];
			off_nxt[AX_RATE_Z]  = cur[AX_RATE_Z];
			// fresh offsets cancel: x doubles, z leaves one g, the rest read zero
			res[AX_ACCEL_X] = cur[AX_ACCEL_X] + cur[AX_ACCEL_X];
			res[AX_ACCEL_Y] = '0;
			res[AX_ACCEL_Z] = {1'b0, grav_q};
			res[AX_RATE_X]  = '0;
			res[AX_RATE_Y]  = '0;
			res[AX_RATE_Z]  = '0;
		end
		result_nxt.accel_x = res[AX_ACCEL_X];
		result_nxt.accel_y = res[AX_ACCEL_Y];
		result_nxt.accel_z = res[AX_ACCEL_Z];
		result_nxt.rate_x  = res[AX_RATE_X];
		result_nxt.rate_y  = res[AX_RATE_Y];
		result_nxt.rate_z  = res[AX_RATE_Z];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				avg_q[a] <= '0;
				off_q[a] <= '0;
			end
		end else if (mv_s4) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				avg_q[a] <= cur[a];
				off_q[a] <= off_nxt[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o) result_q <= result_nxt;
	end

	assign result = result_q;

endmodule
